[design/ray_box_slab_test_macros.svh]
// Assertion macros used by the checker file of the slab test block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define RBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/rbs_pkg.sv]
`default_nettype none
package rbs_pkg;

  localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] FP_POS_INF = 32'h7F80_0000;
  localparam logic [31:0] FP_ZERO    = 32'h0000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BOX  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [63:0] x_pair;
    logic [63:0] y_pair;
    logic [63:0] z_pair;
    logic [31:0] distance_limit;
    logic [1:0]  child_lane;
    logic        last_child;
  } in_item_t;

  typedef struct packed {
    logic        box_hit;
    logic [31:0] entry_distance;
    logic [1:0]  result_lane;
    logic        result_last;
  } out_item_t;

  // Near and far slab distances of one axis.
  typedef struct packed {
    logic [31:0] near_t;
    logic [31:0] far_t;
  } slab_t;

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
    return fp_lt(a, b) || (a == b);
  endfunction

  // Single precision add, round to nearest even, with subnormals.
  function automatic logic [31:0] fp_add(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a;
    logic [31:0] b;
    logic        sx;
    logic [8:0]  ea;
    logic [8:0]  eb;
    logic [8:0]  e;
    logic [8:0]  d;
    logic [8:0]  sh;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [26:0] xa;
    logic [26:0] xb;
    logic [26:0] mant;
    logic [27:0] s;
    logic [4:0]  lz;
    logic        found;
    logic [24:0] m;
    logic        g;
    logic        rs;
    a = a_in;
    b = b_in;
    if (fp_is_nan(a) || fp_is_nan(b)) return FP_QNAN;
    if (a[30:23] == 8'hFF) begin
      if ((b[30:23] == 8'hFF) && (a[31] != b[31])) return FP_QNAN;
      return a;
    end
    if (b[30:23] == 8'hFF) return b;
    if (b[30:0] > a[30:0]) begin
      a = b_in;
      b = a_in;
    end
    sx = a[31];
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    xa = {ma, 3'b000};
    d  = ea - eb;
    if (d >= 9'd27) begin
      xb = {26'd0, |mb};
    end else begin
      xb = {mb, 3'b000} >> d;
      xb[0] = xb[0] | (|({mb, 3'b000} & ((27'd1 << d) - 27'd1)));
    end
    e = ea;
    if (a[31] == b[31]) begin
      s = {1'b0, xa} + {1'b0, xb};
      if (s[27]) begin
        mant = {s[27:2], s[1] | s[0]};
        e = e + 9'd1;
      end else begin
        mant = s[26:0];
      end
    end else begin
      s = {1'b0, xa} - {1'b0, xb};
      if (s == 28'd0) return FP_ZERO;
      lz = 5'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found) begin
          if (s[i]) found = 1'b1;
          else lz = lz + 5'd1;
        end
      end
      if ({4'd0, lz} < (e - 9'd1)) sh = {4'd0, lz};
      else sh = e - 9'd1;
      mant = s[26:0] << sh;
      e = e - sh;
    end
    m  = {1'b0, mant[26:3]};
    g  = mant[2];
    rs = mant[1] | mant[0];
    if (g && (rs || m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      e = e + 9'd1;
    end
    if (e >= 9'd255) return {sx, 8'hFF, 23'd0};
    return {sx, m[23] ? e[7:0] : 8'h00, m[22:0]};
  endfunction

  // Single precision multiply, round to nearest even, with subnormals.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               sx;
    logic [8:0]         ea;
    logic [8:0]         eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        p;
    logic [5:0]         lz;
    logic               found;
    logic signed [10:0] ex;
    logic [10:0]        rsh;
    logic               stk;
    logic [24:0]        m;
    logic               g;
    logic               rs;
    sx = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return FP_QNAN;
    if (a[30:23] == 8'hFF) begin
      if (b[30:0] == 31'd0) return FP_QNAN;
      return {sx, 8'hFF, 23'd0};
    end
    if (b[30:23] == 8'hFF) begin
      if (a[30:0] == 31'd0) return FP_QNAN;
      return {sx, 8'hFF, 23'd0};
    end
    if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) return {sx, 31'd0};
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    lz = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found) begin
        if (p[i]) found = 1'b1;
        else lz = lz + 6'd1;
      end
    end
    p  = p << lz;
    ex = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 11'sd126 - $signed({5'd0, lz});
    stk = 1'b0;
    if (ex < 11'sd1) begin
      rsh = 11'(11'sd1 - ex);
      ex  = 11'sd1;
      if (rsh >= 11'd48) begin
        stk = |p;
        p   = 48'd0;
      end else begin
        stk = |(p & ((48'd1 << rsh) - 48'd1));
        p   = p >> rsh;
      end
    end
    m  = {1'b0, p[47:24]};
    g  = p[23];
    rs = (|p[22:0]) | stk;
    if (g && (rs || m[0])) m = m + 25'd1;
    if (m[24]) begin
      m  = m >> 1;
      ex = ex + 11'sd1;
    end
    if (ex >= 11'sd255) return {sx, 8'hFF, 23'd0};
    return {sx, m[23] ? ex[7:0] : 8'h00, m[22:0]};
  endfunction

endpackage
`default_nettype wire

[design/rbs_stream_if.sv]
`default_nettype none
interface rbs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/rbs_axis.sv]
`default_nettype none
module rbs_axis (
  input  wire logic [31:0]   lo_i,
  input  wire logic [31:0]   hi_i,
  input  wire logic [31:0]   org_i,
  input  wire logic [31:0]   inv_i,
  output rbs_pkg::slab_t     slab_o
);
  import rbs_pkg::*;

  logic        neg;
  logic [31:0] d0;
  logic [31:0] d1;
  logic [31:0] t0;
  logic [31:0] t1;

  // Negative zero and NaN directions count as positive.
  assign neg = fp_lt(inv_i, FP_ZERO);
  assign d0  = fp_add(neg ? hi_i : lo_i, {~org_i[31], org_i[30:0]});
  assign d1  = fp_add(neg ? lo_i : hi_i, {~org_i[31], org_i[30:0]});
  assign t0  = fp_mul(d0, inv_i);
  assign t1  = fp_mul(d1, inv_i);

  assign slab_o.near_t = fp_lt(t1, t0) ? t1 : t0;
  assign slab_o.far_t  = fp_lt(t0, t1) ? t1 : t0;
endmodule
`default_nettype wire

[design/ray_box_slab_test.sv]
// A box item passes from the input register to the result register, where its result waits.
// Throughput: one item per cycle while the output is not stalled; the slab arithmetic of all
// three axes sits between the input register and the result register.
// Ray loads produce no result and take effect when they leave the input register.
// Reset (rst_ni low, asynchronous) empties both registers and zeroes the ray state.
`default_nettype none
module ray_box_slab_test (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rbs_stream_if.sink   in_i,
  rbs_stream_if.source out_o
);
  import rbs_pkg::*;

  logic        s1_valid_q;
  in_item_t    s1_q;
  logic        out_valid_q;
  out_item_t   out_q;
  logic [31:0] origin_q [3];
  logic [31:0] inv_dir_q [3];
  logic [31:0] limit_q;

  logic        advance;
  slab_t       slab [3];
  logic [31:0] entry_c;
  logic [31:0] exit_c;
  logic        hit_c;
  logic [63:0] pairs [3];

  assign pairs[0] = s1_q.x_pair;
  assign pairs[1] = s1_q.y_pair;
  assign pairs[2] = s1_q.z_pair;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_axis u_axis (
      .lo_i  (pairs[a][31:0]),
      .hi_i  (pairs[a][63:32]),
      .org_i (origin_q[a]),
      .inv_i (inv_dir_q[a]),
      .slab_o(slab[a])
    );
  end

  always_comb begin
    entry_c = FP_ZERO;
    exit_c  = limit_q;
    for (int a = 0; a < 3; a++) begin
      if (fp_lt(entry_c, slab[a].near_t)) entry_c = slab[a].near_t;
      if (fp_lt(slab[a].far_t, exit_c)) exit_c = slab[a].far_t;
    end
    hit_c = fp_le(entry_c, exit_c);
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= 32'd0;
      for (int a = 0; a < 3; a++) begin
        origin_q[a]  <= 32'd0;
        inv_dir_q[a] <= 32'd0;
      end
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (advance && (s1_q.opcode == OP_BOX)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (advance && (s1_q.opcode == OP_LOAD)) begin
        for (int a = 0; a < 3; a++) begin
          origin_q[a]  <= pairs[a][31:0];
          inv_dir_q[a] <= pairs[a][63:32];
        end
        limit_q <= s1_q.distance_limit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) s1_q <= in_i.payload;
    if (advance && (s1_q.opcode == OP_BOX)) begin
      out_q.box_hit        <= hit_c;
      out_q.entry_distance <= hit_c ? entry_c : FP_POS_INF;
      out_q.result_lane    <= s1_q.child_lane;
      out_q.result_last    <= s1_q.last_child;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
endmodule
`default_nettype wire

[design/rbs_checker.sv]
`default_nettype none
`include "ray_box_slab_test_macros.svh"
module rbs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        box_hit_i,
  input wire logic [31:0] entry_distance_i,
  input wire logic [1:0]  result_lane_i,
  input wire logic        result_last_i
);
  import rbs_pkg::*;

  logic [35:0] out_bits;
  assign out_bits = {box_hit_i, entry_distance_i, result_lane_i, result_last_i};

  // A stalled result stays put until its transfer.
  `RBS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_bits))
  // A miss always reports positive infinity.
  `RBS_ASSERT_IMP(a_miss_inf, out_valid_i && !box_hit_i, entry_distance_i == FP_POS_INF)
  // Entry starts at positive zero and only grows, so a hit is never negative.
  `RBS_ASSERT_IMP(a_hit_sign, out_valid_i && box_hit_i, !entry_distance_i[31])
  // With the result register empty the input side cannot be blocked.
  `RBS_ASSERT_IMP(a_ready_free, !out_valid_i, in_ready_i)
endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .box_hit_i       (out_o.payload.box_hit),
  .entry_distance_i(out_o.payload.entry_distance),
  .result_lane_i   (out_o.payload.result_lane),
  .result_last_i   (out_o.payload.result_last)
);
`default_nettype wire
